### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; clk and rst_n must be in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tun_pkg.sv
// ---------------------------------------------------------------------------
// tun_pkg
// Widths and types of the triangle unit normal pipeline.
// ---------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_W = 16;                 // Q8.8 vertex coordinate
    localparam int NFRAC   = 14;                 // fraction bits of the normal
    localparam int NORM_W  = NFRAC + 2;          // Q1.14 normal component
    localparam int DIFF_W  = COORD_W + 1;        // edge vector component
    localparam int PROD_W  = 2 * DIFF_W;         // partial cross product
    localparam int CROSS_W = PROD_W + 1;         // cross product component
    localparam int MAG_W   = 31;                 // fitted magnitude
    localparam int SQ_W    = 2 * MAG_W;          // squared magnitude
    localparam int SUM_W   = 64;                 // sum of squares
    localparam int ROOT_W  = SUM_W / 2;          // integer square root
    localparam int QUO_W   = NFRAC + 1;          // quotient, at most 1.0
    localparam int NUM_W   = MAG_W + NFRAC + 1;  // scaled, rounded dividend

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [ROOT_W-1:0]         root_t;

    // fitted cross product as magnitude and sign
    typedef struct packed {
        mag_t [2:0] mag;
        logic [2:0] neg;
    } cvec_t;

endpackage

### hdl/tun_if.sv
// ---------------------------------------------------------------------------
// tun_if
// Valid/ready channels for triangle words and normal words.
// ---------------------------------------------------------------------------
interface tun_vtx_if;
    logic            valid;
    logic            ready;
    tun_pkg::coord_t first_x;
    tun_pkg::coord_t first_y;
    tun_pkg::coord_t first_z;
    tun_pkg::coord_t second_x;
    tun_pkg::coord_t second_y;
    tun_pkg::coord_t second_z;
    tun_pkg::coord_t third_x;
    tun_pkg::coord_t third_y;
    tun_pkg::coord_t third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, output ready);
endinterface

interface tun_nrm_if;
    logic           valid;
    logic           ready;
    tun_pkg::norm_t normal_x;
    tun_pkg::norm_t normal_y;
    tun_pkg::norm_t normal_z;
    logic           degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                    output ready);
endinterface

### hdl/triangle_unit_normal.sv
// Unit normal of a triangle: takes one triangle word per cycle and returns
// one normal word per triangle, in order, through 6 stages of edge vectors,
// cross product and sum of squares, 32 square-root stages at one root bit
// each and 17 load, divide and sign stages, the divide stages at one
// quotient bit each. Throughput is one triangle per clock, but the whole
// pipeline holds while a finished word waits at the output and is not taken.
// A zero-length cross product gives a zero normal with degenerate set.
// ---------------------------------------------------------------------------
// triangle_unit_normal
// Top level: triangle channel in, Q1.14 unit normal channel out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_unit_normal (
    input  logic     clk,
    input  logic     rst_n,
    tun_vtx_if.sink   vtx,
    tun_nrm_if.source nrm
);
    import tun_pkg::*;

    logic               en;
    coord_t [8:0]       vtx_arr;
    logic               front_valid;
    cvec_t              front_cv;
    logic [SUM_W-1:0]   front_sum;
    logic               sqrt_valid;
    root_t              sqrt_root;
    logic [$bits(cvec_t)-1:0] sqrt_side;
    norm_t [2:0]        normal;

    // the pipeline moves whenever the output slot is free or being taken
    assign en        = !nrm.valid || nrm.ready;
    assign vtx.ready = en;

    assign vtx_arr[0] = vtx.first_x;
    assign vtx_arr[1] = vtx.first_y;
    assign vtx_arr[2] = vtx.first_z;
    assign vtx_arr[3] = vtx.second_x;
    assign vtx_arr[4] = vtx.second_y;
    assign vtx_arr[5] = vtx.second_z;
    assign vtx_arr[6] = vtx.third_x;
    assign vtx_arr[7] = vtx.third_y;
    assign vtx_arr[8] = vtx.third_z;

    tun_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vtx.valid),
        .vtx       (vtx_arr),
        .out_valid (front_valid),
        .cv        (front_cv),
        .sum       (front_sum)
    );

    tun_sqrt #(
        .SIDE_W ($bits(cvec_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .radicand  (front_sum),
        .side_in   (front_cv),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    tun_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sqrt_valid),
        .len        (sqrt_root),
        .cv         (cvec_t'(sqrt_side)),
        .out_valid  (nrm.valid),
        .normal     (normal),
        .degenerate (nrm.degenerate)
    );

    assign nrm.normal_x = normal[0];
    assign nrm.normal_y = normal[1];
    assign nrm.normal_z = normal[2];

    // checks
    `ASSERT_IMPLY(a_degen_zero, nrm.valid && nrm.degenerate,
        nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0,
        "degenerate word with nonzero normal")
    `ASSERT_IMPLY(a_unit_range, nrm.valid,
        nrm.normal_x <= 16384 && nrm.normal_x >= -16384 &&
        nrm.normal_y <= 16384 && nrm.normal_y >= -16384 &&
        nrm.normal_z <= 16384 && nrm.normal_z >= -16384,
        "normal component beyond unit range")
    `ASSERT_IMPLY(a_nondegen_nonzero, nrm.valid && !nrm.degenerate,
        nrm.normal_x != '0 || nrm.normal_y != '0 || nrm.normal_z != '0,
        "regular triangle with zero normal")

endmodule

### hdl/tun_front.sv
// ---------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, range fit and sum of squares; six stages.
// ---------------------------------------------------------------------------
module tun_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  tun_pkg::coord_t [8:0]         vtx,
    output logic                          out_valid,
    output tun_pkg::cvec_t                cv,
    output logic [tun_pkg::SUM_W-1:0]     sum
);
    import tun_pkg::*;

    logic [5:0]                vld_reg;
    logic signed [DIFF_W-1:0]  a_reg [3];
    logic signed [DIFF_W-1:0]  b_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] c_reg [3];
    logic [CROSS_W-2:0]        cmag [3];
    logic [CROSS_W-2:0]        cor;
    logic [1:0]                shift;
    cvec_t                     cv4_reg;
    cvec_t                     cv5_reg;
    cvec_t                     cv6_reg;
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SUM_W-1:0]          sum_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // magnitudes of the cross product and the common shift that fits them
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cmag[i] = c_reg[i][CROSS_W-1] ? (CROSS_W-1)'(-c_reg[i])
                                          : (CROSS_W-1)'(c_reg[i]);
        end
        cor = cmag[0] | cmag[1] | cmag[2];
        if (cor[CROSS_W-2])
        begin
            shift = 2'd3;
        end
        else if (cor[CROSS_W-3])
        begin
            shift = 2'd2;
        end
        else if (cor[CROSS_W-4])
        begin
            shift = 2'd1;
        end
        else
        begin
            shift = 2'd0;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= DIFF_W'(vtx[i]) - DIFF_W'(vtx[3 + i]);
                b_reg[i] <= DIFF_W'(vtx[3 + i]) - DIFF_W'(vtx[6 + i]);
            end
            p_reg[0] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[2]);
            p_reg[1] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[1]);
            p_reg[2] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[0]);
            p_reg[3] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[2]);
            p_reg[4] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[1]);
            p_reg[5] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CROSS_W'(p_reg[2 * i]) - CROSS_W'(p_reg[2 * i + 1]);
                cv4_reg.mag[i] <= MAG_W'(cmag[i] >> shift);
                cv4_reg.neg[i] <= c_reg[i][CROSS_W-1];
                sq_reg[i] <= SQ_W'(cv4_reg.mag[i]) * SQ_W'(cv4_reg.mag[i]);
            end
            cv5_reg <= cv4_reg;
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            cv6_reg <= cv5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign cv        = cv6_reg;
    assign sum       = sum_reg;

endmodule

### hdl/tun_sqrt.sv
// ---------------------------------------------------------------------------
// tun_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ---------------------------------------------------------------------------
module tun_sqrt #(
    parameter int SIDE_W = 96
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [tun_pkg::SUM_W-1:0] radicand,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output tun_pkg::root_t            root,
    output logic [SIDE_W-1:0]         side_out
);
    import tun_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [STEPS-1:0]  vld_reg;
    logic [SUM_W-1:0]  rad_reg  [STEPS];
    logic [REM_W-1:0]  rem_reg  [STEPS];
    root_t             root_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic [SUM_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        root_t             root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = side_in;
            assign vld_prev  = in_valid;
        end
        else
        begin : g_next
            assign rad_prev  = rad_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign vld_prev  = vld_reg[j-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[SUM_W-1 -: 2]};
        assign trial  = {root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j]  <= rad_prev << 2;
                rem_reg[j]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[j] <= {root_prev[ROOT_W-2:0], ge};
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

### hdl/tun_div.sv
// ---------------------------------------------------------------------------
// tun_div
// Three pipelined restoring dividers, one quotient bit per stage, and sign.
// ---------------------------------------------------------------------------
module tun_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  tun_pkg::root_t         len,
    input  tun_pkg::cvec_t         cv,
    output logic                   out_valid,
    output tun_pkg::norm_t [2:0]   normal,
    output logic                   degenerate
);
    import tun_pkg::*;

    logic [QUO_W:0]   vld_reg;
    root_t            rem_reg [QUO_W+1][3];
    logic [QUO_W-1:0] nb_reg  [QUO_W+1][3];
    logic [QUO_W-1:0] q_reg   [QUO_W+1][3];
    root_t            len_reg [QUO_W+1];
    logic [2:0]       neg_reg [QUO_W+1];
    logic [NUM_W-1:0] num [3];
    logic             vld_out_reg;
    norm_t [2:0]      normal_reg;
    logic             degen_reg;

    // scaled magnitude plus half the length rounds the quotient
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l] = (NUM_W'(cv.mag[l]) << NFRAC) + NUM_W'(len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[QUO_W-1:0], in_valid};
            vld_out_reg <= vld_reg[QUO_W];
        end
    end

    // load stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= ROOT_W'(num[l][NUM_W-1:QUO_W]);
                nb_reg[0][l]  <= num[l][QUO_W-1:0];
                q_reg[0][l]   <= '0;
            end
            len_reg[0] <= len;
            neg_reg[0] <= cv.neg;
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_step
        logic [ROOT_W:0] rs [3];
        logic [2:0]      ge;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                rs[l] = {rem_reg[s-1][l], nb_reg[s-1][l][QUO_W-1]};
                ge[l] = rs[l] >= {1'b0, len_reg[s-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[s][l] <= ge[l] ? ROOT_W'(rs[l] - {1'b0, len_reg[s-1]})
                                           : ROOT_W'(rs[l]);
                    nb_reg[s][l]  <= nb_reg[s-1][l] << 1;
                    q_reg[s][l]   <= {q_reg[s-1][l][QUO_W-2:0], ge[l]};
                end
                len_reg[s] <= len_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // sign, and the zero-length case
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= (len_reg[QUO_W] == '0);
            for (int l = 0; l < 3; l++)
            begin
                if (len_reg[QUO_W] == '0)
                begin
                    normal_reg[l] <= '0;
                end
                else if (neg_reg[QUO_W][l])
                begin
                    normal_reg[l] <= -NORM_W'(q_reg[QUO_W][l]);
                end
                else
                begin
                    normal_reg[l] <= NORM_W'(q_reg[QUO_W][l]);
                end
            end
        end
    end

    assign out_valid  = vld_out_reg;
    assign normal     = normal_reg;
    assign degenerate = degen_reg;

endmodule

### dv/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_triangle_unit_normal
// Streams triangles into the unit normal pipeline with bursty input and a
// stalling output, predicts each normal in fixed point and checks the
// results in order.
// ---------------------------------------------------------------------------
module tb_triangle_unit_normal;
    import tun_pkg::*;

    typedef struct packed {
        norm_t nx;
        norm_t ny;
        norm_t nz;
        logic  degen;
    } normal_word_t;

    // expected normals in order, with error tally
    class normal_board;
        normal_word_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // magnitude of a 64-bit signed value
        function automatic longint unsigned mag64(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        // common right shift so every magnitude is below 2^31
        function automatic void fit3(ref longint v[3]);
            longint unsigned m, a;
            int k;
            m = 0;
            k = 0;
            foreach (v[i])
                if (mag64(v[i]) > m)
                    m = mag64(v[i]);
            while ((m >> k) >= 64'h8000_0000)
                k++;
            if (k != 0)
                foreach (v[i])
                begin
                    a = mag64(v[i]) >> k;
                    v[i] = v[i] < 0 ? -longint'(a) : longint'(a);
                end
        endfunction

        function automatic longint unsigned root64(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'h1 << 62;
            while (b > s)
                b >>= 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // compute the normal of an accepted triangle
        function void note_triangle(coord_t p[9]);
            longint ea[3], eb[3], c[3];
            longint unsigned s, len, m, q;
            normal_word_t w;
            norm_t comp[3];
            for (int i = 0; i < 3; i++)
            begin
                ea[i] = longint'(p[i]) - longint'(p[3+i]);
                eb[i] = longint'(p[3+i]) - longint'(p[6+i]);
            end
            fit3(ea);
            fit3(eb);
            c[0] = ea[1] * eb[2] - ea[2] * eb[1];
            c[1] = ea[2] * eb[0] - ea[0] * eb[2];
            c[2] = ea[0] * eb[1] - ea[1] * eb[0];
            fit3(c);
            s = 0;
            foreach (c[i])
                s += mag64(c[i]) * mag64(c[i]);
            if (s == 0)
                w = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
            else
            begin
                len = root64(s);
                for (int i = 0; i < 3; i++)
                begin
                    m = mag64(c[i]);
                    q = ((m << NFRAC) + (len >> 1)) / len;
                    if (q > (64'h1 << NFRAC))
                        q = 64'h1 << NFRAC;
                    if (c[i] < 0)
                        q = 64'h0 - q;
                    comp[i] = norm_t'(q);
                end
                w = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: 1'b0};
            end
            pending.push_back(w);
        endfunction

        // compare an output word with the oldest expectation
        function void check_normal(normal_word_t got);
            normal_word_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected normal word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"normal mismatch: exp x=%0d y=%0d z=%0d d=%0b",
                              " got x=%0d y=%0d z=%0d d=%0b"},
                             want.nx, want.ny, want.nz, want.degen,
                             got.nx, got.ny, got.nz, got.degen);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tun_vtx_if vtx ();
    tun_nrm_if nrm ();
    normal_board board;
    int stall_mode;

    triangle_unit_normal dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx.sink),
        .nrm   (nrm.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // scoreboard updates on accepted words
    always @(posedge clk)
    begin
        if (rst_n && vtx.valid && vtx.ready)
            board.note_triangle('{vtx.first_x, vtx.first_y, vtx.first_z,
                                  vtx.second_x, vtx.second_y, vtx.second_z,
                                  vtx.third_x, vtx.third_y, vtx.third_z});
        if (rst_n && nrm.valid && nrm.ready)
            board.check_normal('{nrm.normal_x, nrm.normal_y, nrm.normal_z,
                                 nrm.degenerate});
    end

    // receiver stall pattern, mode changes over the run
    always @(posedge clk)
    begin
        case (stall_mode)
            0: nrm.ready <= 1'b1;
            1: nrm.ready <= ($urandom_range(3) != 0);
            2: nrm.ready <= ($urandom_range(3) == 0);
            default: nrm.ready <= $urandom_range(1);
        endcase
    end

    // present one triangle at the current edge and hold it until taken
    task automatic send_triangle(coord_t p[9]);
        vtx.valid    <= 1'b1;
        vtx.first_x  <= p[0];
        vtx.first_y  <= p[1];
        vtx.first_z  <= p[2];
        vtx.second_x <= p[3];
        vtx.second_y <= p[4];
        vtx.second_z <= p[5];
        vtx.third_x  <= p[6];
        vtx.third_y  <= p[7];
        vtx.third_z  <= p[8];
        do
            @(posedge clk);
        while (!vtx.ready);
    endtask

    task automatic go_idle(int n);
        vtx.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random coordinate with frequent small and extreme values
    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2: return coord_t'($signed($urandom_range(32)) - 16);
            default: return coord_t'($signed($urandom_range(2048)) - 1024);
        endcase
    endfunction

    task automatic random_triangle();
        coord_t p[9];
        int kind;
        foreach (p[i])
            p[i] = rand_coord();
        kind = $urandom_range(9);
        // collinear or coincident vertices for the degenerate path
        if (kind == 0)
            for (int i = 0; i < 3; i++)
                p[6+i] = p[3+i];
        else if (kind == 1)
            for (int i = 0; i < 3; i++)
            begin
                p[3+i] = p[i] + coord_t'(3);
                p[6+i] = p[i] + coord_t'(6);
            end
        send_triangle(p);
    endtask

    initial
    begin
        coord_t p[9];
        int n;
        board = new();
        stall_mode = 0;
        rst_n = 1'b0;
        vtx.valid = 1'b0;
        vtx.first_x = '0; vtx.first_y = '0; vtx.first_z = '0;
        vtx.second_x = '0; vtx.second_y = '0; vtx.second_z = '0;
        vtx.third_x = '0; vtx.third_y = '0; vtx.third_z = '0;
        nrm.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero, axis-aligned, extremes, full-range edges
        p = '{default: '0};
        send_triangle(p);
        p = '{16'sh0100, 0, 0, 0, 0, 0, 0, 16'sh0100, 0};
        send_triangle(p);
        p = '{0, 16'sh0100, 0, 0, 0, 0, 0, 0, 16'sh0100};
        send_triangle(p);
        p = '{0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 0};
        send_triangle(p);
        p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_triangle(p);
        p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh8000};
        send_triangle(p);
        p = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh8000};
        send_triangle(p);
        p = '{16'sh7fff, 0, 0, 16'sh8000, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_triangle(p);
        p = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
        send_triangle(p);
        p = '{-16'sd1, -16'sd1, -16'sd1, 0, 0, 0, 1, 2, 3};
        send_triangle(p);
        p = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
        send_triangle(p);
        p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
        send_triangle(p);
        p = '{16'sh1234, -16'sd77, 16'sh0abc, 16'sh8000, 16'sh7fff, 0,
              3, -16'sd3, 16'sh5555};
        send_triangle(p);
        go_idle(1);

        // random bursts with occasional gaps, stall mode redrawn every burst
        n = 0;
        while (n < 850)
        begin
            int burst;
            burst = $urandom_range(40, 1);
            stall_mode = $urandom_range(3);
            for (int i = 0; i < burst && n < 850; i++, n++)
                random_triangle();
            if ($urandom_range(2) != 0)
                go_idle($urandom_range(12, 1));
        end
        vtx.valid <= 1'b0;

        stall_mode = 1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
